// ----- rtl/core/cbob_pkg.sv -----
package cbob_pkg;

  // fixed field widths
  localparam int unsigned CH_W       = 8;
  localparam int unsigned SIDE_CFG_W = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned OUT_W      = 10;
  localparam int unsigned CMD_W      = 4;
  localparam int unsigned NBANDS     = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN_RED     = 3'd0,
    REG_MEAN_GREEN   = 3'd1,
    REG_MEAN_BLUE    = 3'd2,
    REG_SPREAD_RED   = 3'd3,
    REG_SPREAD_GREEN = 3'd4,
    REG_SPREAD_BLUE  = 3'd5,
    REG_FRAME_WIDTH  = 3'd6,
    REG_FRAME_HEIGHT = 3'd7
  } reg_idx_e;

  // register reset values
  localparam logic [CH_W-1:0]       MEAN_RED_RST     = 8'd245;
  localparam logic [CH_W-1:0]       MEAN_GREEN_RST   = 8'd5;
  localparam logic [CH_W-1:0]       MEAN_BLUE_RST    = 8'd30;
  localparam logic [CH_W-1:0]       SPREAD_RED_RST   = 8'd10;
  localparam logic [CH_W-1:0]       SPREAD_GREEN_RST = 8'd5;
  localparam logic [CH_W-1:0]       SPREAD_BLUE_RST  = 8'd20;
  localparam logic [SIDE_CFG_W-1:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [SIDE_CFG_W-1:0] FRAME_HEIGHT_RST = 11'd240;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE    = 4'd0,
    CMD_STOP    = 4'd1,
    CMD_FWD     = 4'd2,
    CMD_DRIFT_L = 4'd3,
    CMD_DRIFT_R = 4'd4,
    CMD_BACK    = 4'd5,
    CMD_BACK_L  = 4'd6,
    CMD_BACK_R  = 4'd7,
    CMD_TURN_L  = 4'd8,
    CMD_TURN_R  = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    BAND_LEFT   = 2'd0,
    BAND_CENTRE = 2'd1,
    BAND_RIGHT  = 2'd2
  } band_e;

  typedef struct packed {
    logic key_up;
    logic key_down;
    logic key_left;
    logic key_right;
    logic able_to_run;
  } key_t;

  // frame summary handed from the accumulator to the decision stage
  typedef struct packed {
    logic             any_hit;
    key_t             keys;
    logic [OUT_W-1:0] box_col_min;
    logic [OUT_W-1:0] box_col_max;
    logic [OUT_W-1:0] box_row_min;
    logic [OUT_W-1:0] box_row_max;
    logic [OUT_W-1:0] left_nearest;
    logic [OUT_W-1:0] centre_nearest;
    logic [OUT_W-1:0] right_nearest;
  } snap_t;

  typedef struct packed {
    logic             object_found;
    logic             obstacle;
    cmd_e             command;
    logic [OUT_W-1:0] box_col_min;
    logic [OUT_W-1:0] box_col_max;
    logic [OUT_W-1:0] box_row_min;
    logic [OUT_W-1:0] box_row_max;
    logic [OUT_W-1:0] left_nearest;
    logic [OUT_W-1:0] centre_nearest;
    logic [OUT_W-1:0] right_nearest;
  } res_t;

endpackage

// ----- rtl/core/cbob_if.sv -----
interface cbob_pix_if import cbob_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            key_up;
  logic            key_down;
  logic            key_left;
  logic            key_right;
  logic            able_to_run;

  modport source (
    output valid, red, green, blue, key_up, key_down, key_left, key_right, able_to_run,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, key_up, key_down, key_left, key_right, able_to_run,
    output ready
  );
endinterface

interface cbob_res_if import cbob_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             object_found;
  logic             obstacle;
  logic [CMD_W-1:0] command;
  logic [OUT_W-1:0] box_col_min;
  logic [OUT_W-1:0] box_col_max;
  logic [OUT_W-1:0] box_row_min;
  logic [OUT_W-1:0] box_row_max;
  logic [OUT_W-1:0] left_nearest;
  logic [OUT_W-1:0] centre_nearest;
  logic [OUT_W-1:0] right_nearest;

  modport source (
    output valid, object_found, obstacle, command, box_col_min, box_col_max,
           box_row_min, box_row_max, left_nearest, centre_nearest, right_nearest,
    input  ready
  );
  modport sink (
    input  valid, object_found, obstacle, command, box_col_min, box_col_max,
           box_row_min, box_row_max, left_nearest, centre_nearest, right_nearest,
    output ready
  );
endinterface

// ----- rtl/core/cbob_match.sv -----
module cbob_match import cbob_pkg::*; (
  input  logic [CH_W-1:0] red_i,
  input  logic [CH_W-1:0] green_i,
  input  logic [CH_W-1:0] blue_i,
  input  logic [CH_W-1:0] mean_red_i,
  input  logic [CH_W-1:0] mean_green_i,
  input  logic [CH_W-1:0] mean_blue_i,
  input  logic [CH_W-1:0] spread_red_i,
  input  logic [CH_W-1:0] spread_green_i,
  input  logic [CH_W-1:0] spread_blue_i,
  output logic            match_o
);

  localparam int unsigned WIN_W = CH_W + 2;

  logic [2:0][CH_W-1:0]  lvl;
  logic [2:0][CH_W-1:0]  mean;
  logic [2:0][CH_W-1:0]  spread;
  logic [2:0]            in_win;

  assign lvl    = {blue_i, green_i, red_i};
  assign mean   = {mean_blue_i, mean_green_i, mean_red_i};
  assign spread = {spread_blue_i, spread_green_i, spread_red_i};

  // level + 2d >= mean and level <= mean + 2d, kept unsigned
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      in_win[c] =
        (WIN_W'(lvl[c]) + (WIN_W'(spread[c]) << 1) >= WIN_W'(mean[c])) &&
        (WIN_W'(lvl[c]) <= WIN_W'(mean[c]) + (WIN_W'(spread[c]) << 1));
    end
  end

  assign match_o = &in_win;

endmodule

// ----- rtl/core/cbob_accum.sv -----
module cbob_accum import cbob_pkg::*; #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic                               match_i,
  input  key_t                               keys_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]      width_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]      height_i,
  output logic                               snap_valid_o,
  input  logic                               snap_ready_i,
  output snap_t                              snap_o,
  output logic [2*$clog2(MAX_SIDE)-1:0]      sum_o,
  output logic [$clog2(MAX_SIDE+1)-1:0]      cnt_o,
  output logic [$clog2(MAX_SIDE+1)-1:0]      height_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned CNT_W  = SIDE_W;
  localparam int unsigned SUM_W  = 2 * IDX_W;
  localparam int unsigned BAND_W = SIDE_W + 2;

  logic [IDX_W-1:0] col_q, col_d, row_q, row_d;
  logic             done_q, done_d, any_hit_q, any_hit_d;
  logic [IDX_W-1:0] cmin_q, cmin_d, cmax_q, cmax_d, rmin_q, rmin_d, rmax_q, rmax_d;
  logic [NBANDS-1:0][SUM_W-1:0] sum_q, sum_d;
  logic [NBANDS-1:0][CNT_W-1:0] cnt_q, cnt_d;
  logic [NBANDS-1:0][IDX_W-1:0] max_q, max_d;

  logic              snap_valid_q, snap_valid_d;
  snap_t             snap_q, snap_d;
  logic [SUM_W-1:0]  ssum_q, ssum_d;
  logic [CNT_W-1:0]  scnt_q, scnt_d;
  logic [SIDE_W-1:0] sh_q, sh_d;

  logic              fire, hit, row_end, col_end, frame_end;
  logic [BAND_W-1:0] col3;
  logic [NBANDS-1:0] band_sel;

  assign ready_o = !snap_valid_q || snap_ready_i;
  assign fire    = valid_i && ready_o;

  // band split without a divider: left when 3(col+1) <= w, right when 3col > 2w
  assign col3 = (BAND_W'(col_q) << 1) + BAND_W'(col_q);
  always_comb begin
    band_sel = '0;
    if (col3 + BAND_W'(3) <= BAND_W'(width_i)) begin
      band_sel[BAND_LEFT] = 1'b1;
    end else if (col3 > (BAND_W'(width_i) << 1)) begin
      band_sel[BAND_RIGHT] = 1'b1;
    end else begin
      band_sel[BAND_CENTRE] = 1'b1;
    end
  end

  assign row_end = SIDE_W'(row_q) + SIDE_W'(1) >= height_i;
  assign col_end = SIDE_W'(col_q) + SIDE_W'(1) >= width_i;
  assign hit     = fire && !done_q && match_i;

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    done_d       = done_q;
    any_hit_d    = any_hit_q;
    cmin_d       = cmin_q;
    cmax_d       = cmax_q;
    rmin_d       = rmin_q;
    rmax_d       = rmax_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    max_d        = max_q;
    snap_valid_d = snap_valid_q && !snap_ready_i;
    snap_d       = snap_q;
    ssum_d       = ssum_q;
    scnt_d       = scnt_q;
    sh_d         = sh_q;
    frame_end    = 1'b0;

    if (hit) begin
      any_hit_d = 1'b1;
      done_d    = 1'b1;
      if (!any_hit_q) begin
        cmin_d = col_q;
        cmax_d = col_q;
        rmin_d = row_q;
        rmax_d = row_q;
      end else begin
        if (col_q < cmin_q) cmin_d = col_q;
        if (col_q > cmax_q) cmax_d = col_q;
        if (row_q < rmin_q) rmin_d = row_q;
        if (row_q > rmax_q) rmax_d = row_q;
      end
      for (int b = 0; b < NBANDS; b++) begin
        if (band_sel[b]) begin
          sum_d[b] = sum_q[b] + SUM_W'(row_q);
          cnt_d[b] = cnt_q[b] + CNT_W'(1);
          if (row_q > max_q[b]) max_d[b] = row_q;
        end
      end
    end

    if (fire) begin
      if (row_end) begin
        row_d  = '0;
        done_d = 1'b0;
        if (col_end) begin
          frame_end = 1'b1;
        end else begin
          col_d = col_q + IDX_W'(1);
        end
      end else begin
        row_d = row_q + IDX_W'(1);
      end
    end

    // frame end: capture the summary including this pixel, then start over
    if (frame_end) begin
      snap_valid_d          = 1'b1;
      snap_d.any_hit        = any_hit_d;
      snap_d.keys           = keys_i;
      snap_d.box_col_min    = OUT_W'(cmin_d);
      snap_d.box_col_max    = OUT_W'(cmax_d);
      snap_d.box_row_min    = OUT_W'(rmin_d);
      snap_d.box_row_max    = OUT_W'(rmax_d);
      snap_d.left_nearest   = OUT_W'(max_d[BAND_LEFT]);
      snap_d.centre_nearest = OUT_W'(max_d[BAND_CENTRE]);
      snap_d.right_nearest  = OUT_W'(max_d[BAND_RIGHT]);
      ssum_d                = sum_d[BAND_CENTRE];
      scnt_d                = cnt_d[BAND_CENTRE];
      sh_d                  = height_i;

      col_d     = '0;
      row_d     = '0;
      done_d    = 1'b0;
      any_hit_d = 1'b0;
      cmin_d    = '0;
      cmax_d    = '0;
      rmin_d    = '0;
      rmax_d    = '0;
      sum_d     = '0;
      cnt_d     = '0;
      max_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      done_q       <= 1'b0;
      any_hit_q    <= 1'b0;
      cmin_q       <= '0;
      cmax_q       <= '0;
      rmin_q       <= '0;
      rmax_q       <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      max_q        <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      done_q       <= done_d;
      any_hit_q    <= any_hit_d;
      cmin_q       <= cmin_d;
      cmax_q       <= cmax_d;
      rmin_q       <= rmin_d;
      rmax_q       <= rmax_d;
      sum_q        <= sum_d;
      cnt_q        <= cnt_d;
      max_q        <= max_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    ssum_q <= ssum_d;
    scnt_q <= scnt_d;
    sh_q   <= sh_d;
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;
  assign sum_o        = ssum_q;
  assign cnt_o        = scnt_q;
  assign height_o     = sh_q;

  a_done_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> any_hit_q)
    else $error("column marked done without any recorded hit");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_hit_q |-> (cmin_q <= cmax_q) && (rmin_q <= rmax_q))
    else $error("bounding box min above max");

  a_empty_band_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[BAND_CENTRE] == '0) |-> (sum_q[BAND_CENTRE] == '0))
    else $error("centre band sum without hits");

endmodule

// ----- rtl/core/cbob_decide.sv -----
module cbob_decide import cbob_pkg::*; #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          snap_valid_i,
  output logic                          snap_ready_o,
  input  snap_t                         snap_i,
  input  logic [2*$clog2(MAX_SIDE)-1:0] sum_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0] cnt_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0] height_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output res_t                          res_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned SUM_W  = 2 * IDX_W;
  localparam int unsigned H7_W   = SIDE_W + 3;
  localparam int unsigned PROD_W = SIDE_W + H7_W;
  localparam int unsigned S10_W  = SUM_W + 4;
  localparam int unsigned CMP_W  = (PROD_W > S10_W) ? PROD_W : S10_W;

  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;
  logic [H7_W-1:0]   h7;
  logic [CMP_W-1:0]  lhs, rhs;
  logic              obst;
  logic              load;

  function automatic cmd_e back_cmd(input key_t k);
    cmd_e c;
    if (k.key_left) begin
      c = CMD_BACK_L;
    end else if (k.key_right) begin
      c = CMD_BACK_R;
    end else if (k.key_up) begin
      c = CMD_STOP;
    end else begin
      c = CMD_BACK;
    end
    return c;
  endfunction

  assign snap_ready_o = !res_valid_q || res_ready_i;
  assign load         = snap_valid_i && snap_ready_o;

  // obstacle when a hit exists and the centre band is empty or 10*sum >= 7*height*count on it
  assign h7   = (H7_W'(height_i) << 3) - H7_W'(height_i);
  assign lhs  = (CMP_W'(sum_i) << 3) + (CMP_W'(sum_i) << 1);
  assign rhs  = CMP_W'(cnt_i) * CMP_W'(h7);
  assign obst = snap_i.any_hit && ((cnt_i == '0) || (lhs >= rhs));

  always_comb begin
    res_d                = res_q;
    res_valid_d          = res_valid_q && !res_ready_i;
    if (load) begin
      res_valid_d          = 1'b1;
      res_d.object_found   = snap_i.any_hit;
      res_d.obstacle       = obst;
      res_d.box_col_min    = snap_i.box_col_min;
      res_d.box_col_max    = snap_i.box_col_max;
      res_d.box_row_min    = snap_i.box_row_min;
      res_d.box_row_max    = snap_i.box_row_max;
      res_d.left_nearest   = snap_i.left_nearest;
      res_d.centre_nearest = snap_i.centre_nearest;
      res_d.right_nearest  = snap_i.right_nearest;
      if (!snap_i.any_hit) begin
        res_d.command = CMD_NONE;
      end else if (obst) begin
        res_d.command = snap_i.keys.key_down ? back_cmd(snap_i.keys) : CMD_STOP;
      end else if (snap_i.keys.key_up && snap_i.keys.able_to_run) begin
        if (snap_i.keys.key_left) begin
          res_d.command = CMD_DRIFT_L;
        end else if (snap_i.keys.key_right) begin
          res_d.command = CMD_DRIFT_R;
        end else if (snap_i.keys.key_down) begin
          res_d.command = CMD_STOP;
        end else begin
          res_d.command = CMD_FWD;
        end
      end else if (snap_i.keys.key_down) begin
        res_d.command = back_cmd(snap_i.keys);
      end else if (snap_i.keys.key_left && !snap_i.keys.key_right &&
                   snap_i.keys.able_to_run) begin
        res_d.command = CMD_TURN_L;
      end else if (!snap_i.keys.key_left && snap_i.keys.key_right &&
                   snap_i.keys.able_to_run) begin
        res_d.command = CMD_TURN_R;
      end else begin
        res_d.command = CMD_STOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_nothing_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.object_found |-> (res_q.command == CMD_NONE) && !res_q.obstacle)
    else $error("empty frame gave a command or obstacle");

  a_obstacle_brakes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.obstacle |->
      (res_q.command == CMD_STOP) || (res_q.command == CMD_BACK) ||
      (res_q.command == CMD_BACK_L) || (res_q.command == CMD_BACK_R))
    else $error("obstacle flagged but command moves forward or turns");

endmodule

// ----- rtl/core/color_box_obstacle_brake.sv -----
// color box obstacle brake: column-major frames, one pixel request per cycle when not stalled
// result path: after its last pixel is accepted, a frame passes the input, summary and result registers
// throughput: 1 pixel per cycle unless frame results back up; each pixel needs only
//   window compares and accumulator updates between the input register and the state registers
// reset: rst_ni async active low; clears the frame counters, accumulators and all
//   valid flags, loads the configuration registers with their default values
module color_box_obstacle_brake import cbob_pkg::*; #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cbob_pix_if.sink              pix_i,
  cbob_res_if.source            res_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned SUM_W  = 2 * IDX_W;

  // configuration registers; the user must write them only between frames, the block does not enforce it
  logic [CH_W-1:0]       mean_red_q, mean_green_q, mean_blue_q;
  logic [CH_W-1:0]       spread_red_q, spread_green_q, spread_blue_q;
  logic [SIDE_CFG_W-1:0] frame_width_q, frame_height_q;

  // input register stage
  logic            pix_valid_q, pix_valid_d;
  logic [CH_W-1:0] red_q, green_q, blue_q;
  key_t            keys_q;
  logic            load;

  logic              acc_ready;
  logic              match;
  logic [SIDE_W-1:0] width_s, height_s;

  logic              snap_valid, snap_ready;
  snap_t             snap;
  logic [SUM_W-1:0]  snap_sum;
  logic [SIDE_W-1:0] snap_cnt, snap_h;
  logic              res_valid;
  res_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_red_q     <= MEAN_RED_RST;
      mean_green_q   <= MEAN_GREEN_RST;
      mean_blue_q    <= MEAN_BLUE_RST;
      spread_red_q   <= SPREAD_RED_RST;
      spread_green_q <= SPREAD_GREEN_RST;
      spread_blue_q  <= SPREAD_BLUE_RST;
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MEAN_RED:     mean_red_q     <= cfg_data_i[CH_W-1:0];
        REG_MEAN_GREEN:   mean_green_q   <= cfg_data_i[CH_W-1:0];
        REG_MEAN_BLUE:    mean_blue_q    <= cfg_data_i[CH_W-1:0];
        REG_SPREAD_RED:   spread_red_q   <= cfg_data_i[CH_W-1:0];
        REG_SPREAD_GREEN: spread_green_q <= cfg_data_i[CH_W-1:0];
        REG_SPREAD_BLUE:  spread_blue_q  <= cfg_data_i[CH_W-1:0];
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[SIDE_CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[SIDE_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // frame sizes are clamped to 1..MAX_SIDE where they are used
  always_comb begin
    if (frame_width_q == '0) begin
      width_s = SIDE_W'(1);
    end else if (32'(frame_width_q) > MAX_SIDE) begin
      width_s = SIDE_W'(MAX_SIDE);
    end else begin
      width_s = SIDE_W'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_s = SIDE_W'(1);
    end else if (32'(frame_height_q) > MAX_SIDE) begin
      height_s = SIDE_W'(MAX_SIDE);
    end else begin
      height_s = SIDE_W'(frame_height_q);
    end
  end

  // input stage takes a new request whenever the accumulator drains it;
  // only two pending frame results stall the pixel stream
  assign pix_i.ready = !pix_valid_q || acc_ready;
  assign load        = pix_i.valid && pix_i.ready;

  always_comb begin
    pix_valid_d = pix_valid_q;
    if (load) begin
      pix_valid_d = 1'b1;
    end else if (acc_ready) begin
      pix_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else begin
      pix_valid_q <= pix_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      red_q              <= pix_i.red;
      green_q            <= pix_i.green;
      blue_q             <= pix_i.blue;
      keys_q.key_up      <= pix_i.key_up;
      keys_q.key_down    <= pix_i.key_down;
      keys_q.key_left    <= pix_i.key_left;
      keys_q.key_right   <= pix_i.key_right;
      keys_q.able_to_run <= pix_i.able_to_run;
    end
  end

  // color window test on the registered pixel
  cbob_match u_match (
    .red_i          (red_q),
    .green_i        (green_q),
    .blue_i         (blue_q),
    .mean_red_i     (mean_red_q),
    .mean_green_i   (mean_green_q),
    .mean_blue_i    (mean_blue_q),
    .spread_red_i   (spread_red_q),
    .spread_green_i (spread_green_q),
    .spread_blue_i  (spread_blue_q),
    .match_o        (match)
  );

  // scan position, first hit per column, box and band accumulators;
  // holds a frame summary register at frame end
  cbob_accum #(
    .MAX_SIDE (MAX_SIDE)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (pix_valid_q),
    .ready_o      (acc_ready),
    .match_i      (match),
    .keys_i       (keys_q),
    .width_i      (width_s),
    .height_i     (height_s),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap),
    .sum_o        (snap_sum),
    .cnt_o        (snap_cnt),
    .height_o     (snap_h)
  );

  // obstacle test (one multiply) and drive command, into the result register
  cbob_decide #(
    .MAX_SIDE (MAX_SIDE)
  ) u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .sum_i        (snap_sum),
    .cnt_i        (snap_cnt),
    .height_i     (snap_h),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res)
  );

  assign res_o.valid          = res_valid;
  assign res_o.object_found   = res.object_found;
  assign res_o.obstacle       = res.obstacle;
  assign res_o.command        = res.command;
  assign res_o.box_col_min    = res.box_col_min;
  assign res_o.box_col_max    = res.box_col_max;
  assign res_o.box_row_min    = res.box_row_min;
  assign res_o.box_row_max    = res.box_row_max;
  assign res_o.left_nearest   = res.left_nearest;
  assign res_o.centre_nearest = res.centre_nearest;
  assign res_o.right_nearest  = res.right_nearest;

endmodule
